[sv/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

[sv/nfa_pkg.sv]
// Shared types, constants and helpers of the NFA matcher.
`default_nettype none
package nfa_pkg;

  localparam int NUM_STATES = 64;
  localparam int STATE_W    = $clog2(NUM_STATES);
  localparam int PTR_W      = 7;
  localparam int LABEL_W    = 9;
  localparam int SYM_W      = 8;

  localparam logic [LABEL_W-1:0] LBL_EPS    = 9'd256;
  localparam logic [LABEL_W-1:0] LBL_ACCEPT = 9'd257;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_BEGIN = 2'd1,
    CMD_STEP  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [LABEL_W-1:0] label;
    logic [PTR_W-1:0]   nxt;
    logic [PTR_W-1:0]   alt;
  } entry_t;

  typedef struct packed {
    logic load_wr;
    logic start_begin;
    logic start_step;
    logic scan_issue;
    logic scan_proc;
    logic clo_issue;
    logic clo_proc;
    logic commit;
    logic res_load;
  } ctrl_t;

  typedef struct packed {
    logic scan_empty;
    logic work_empty;
    logic out_free;
    logic last;
  } stat_t;

  // Index of the lowest set bit.
  function automatic logic [STATE_W-1:0] first_set(input logic [NUM_STATES-1:0] v);
    logic [STATE_W-1:0] r;
    r = '0;
    for (int i = NUM_STATES - 1; i >= 0; i--) begin
      if (v[i]) r = STATE_W'(i);
    end
    return r;
  endfunction

  function automatic logic ptr_valid(input logic [PTR_W-1:0] p);
    return p < PTR_W'(NUM_STATES);
  endfunction

endpackage
`default_nettype wire

[sv/nfa_if.sv]
// Channel interfaces: input items, results and the start-state register.
`default_nettype none
interface nfa_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [5:0] entry_index;
  logic [8:0] entry_label;
  logic [6:0] entry_next;
  logic [6:0] entry_alt;
  logic [7:0] symbol;
  logic       is_last;
  modport source (output valid, cmd, entry_index, entry_label, entry_next, entry_alt,
                  symbol, is_last, input ready);
  modport sink (input valid, cmd, entry_index, entry_label, entry_next, entry_alt,
                symbol, is_last, output ready);
endinterface

interface nfa_out_if;
  logic valid;
  logic ready;
  logic accepted;
  modport source (output valid, accepted, input ready);
  modport sink (input valid, accepted, output ready);
endinterface

interface nfa_cfg_if;
  logic       valid;
  logic       ready;
  logic [5:0] start_state;
  modport source (output valid, start_state, input ready);
  modport sink (input valid, start_state, output ready);
endinterface
`default_nettype wire

[sv/nfa_ctrl.sv]
// Sequencer of the matcher: scan, closure and result phases.
`default_nettype none
module nfa_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [1:0]    in_cmd_i,
  output logic          in_ready_o,
  input  nfa_pkg::stat_t stat_i,
  output nfa_pkg::ctrl_t ctrl_o
);
  import nfa_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE      = 6'b000001,
    ST_SCAN_ISS  = 6'b000010,
    ST_SCAN_PROC = 6'b000100,
    ST_CLO_ISS   = 6'b001000,
    ST_CLO_PROC  = 6'b010000,
    ST_FINISH    = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (cmd_e'(in_cmd_i))
            CMD_LOAD:  ctrl_o.load_wr = 1'b1;
            CMD_BEGIN: begin
              ctrl_o.start_begin = 1'b1;
              state_d = ST_CLO_ISS;
            end
            CMD_STEP: begin
              ctrl_o.start_step = 1'b1;
              state_d = ST_SCAN_ISS;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN_ISS: begin
        if (stat_i.scan_empty) begin
          state_d = ST_CLO_ISS;
        end else begin
          ctrl_o.scan_issue = 1'b1;
          state_d = ST_SCAN_PROC;
        end
      end
      ST_SCAN_PROC: begin
        ctrl_o.scan_proc = 1'b1;
        state_d = ST_SCAN_ISS;
      end
      ST_CLO_ISS: begin
        if (stat_i.work_empty) begin
          state_d = ST_FINISH;
        end else begin
          ctrl_o.clo_issue = 1'b1;
          state_d = ST_CLO_PROC;
        end
      end
      ST_CLO_PROC: begin
        ctrl_o.clo_proc = 1'b1;
        state_d = ST_CLO_ISS;
      end
      ST_FINISH: begin
        // when a result is due, hold until the result register is free
        if (!stat_i.last || stat_i.out_free) begin
          ctrl_o.commit   = 1'b1;
          ctrl_o.res_load = stat_i.last;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

endmodule
`default_nettype wire

[sv/nfa_dp.sv]
// Datapath of the matcher: NFA table, state-set vectors and result register.
`default_nettype none
module nfa_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  nfa_pkg::ctrl_t                ctrl_i,
  output nfa_pkg::stat_t                stat_o,
  input  logic [nfa_pkg::STATE_W-1:0]   entry_index_i,
  input  logic [nfa_pkg::LABEL_W-1:0]   entry_label_i,
  input  logic [nfa_pkg::PTR_W-1:0]     entry_next_i,
  input  logic [nfa_pkg::PTR_W-1:0]     entry_alt_i,
  input  logic [nfa_pkg::SYM_W-1:0]     symbol_i,
  input  logic                          is_last_i,
  input  logic                          cfg_we_i,
  input  logic [nfa_pkg::STATE_W-1:0]   cfg_start_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          out_accepted_o
);
  import nfa_pkg::*;

  entry_t mem_q [NUM_STATES];
  entry_t rd_q;
  logic [STATE_W-1:0] cur_q, rd_addr;

  logic [NUM_STATES-1:0] active_q, scan_q, work_q, seen_q, pend_q;
  logic [NUM_STATES-1:0] scan_d, work_d, seen_d, pend_d, active_d;
  logic acc_q, acc_d;
  logic last_q, last_d;
  logic [SYM_W-1:0] sym_q;
  logic [STATE_W-1:0] start_q;
  logic res_valid_q, res_valid_d, res_q;
  logic [STATE_W-1:0] scan_idx, work_idx;

  assign scan_idx = first_set(scan_q);
  assign work_idx = first_set(work_q);
  assign rd_addr  = ctrl_i.scan_issue ? scan_idx : work_idx;

  // Table: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_wr) begin
      mem_q[entry_index_i] <= '{label: entry_label_i, nxt: entry_next_i, alt: entry_alt_i};
    end
    if (ctrl_i.scan_issue || ctrl_i.clo_issue) begin
      rd_q  <= mem_q[rd_addr];
      cur_q <= rd_addr;
    end
    if (ctrl_i.start_step) sym_q <= symbol_i;
  end

  always_comb begin
    scan_d    = scan_q;
    work_d    = work_q;
    seen_d    = seen_q;
    pend_d    = pend_q;
    acc_d     = acc_q;
    active_d  = active_q;
    last_d    = last_q;
    if (ctrl_i.start_begin || ctrl_i.start_step) begin
      work_d = '0;
      seen_d = '0;
      pend_d = '0;
      acc_d  = 1'b0;
      last_d = is_last_i;
      scan_d = ctrl_i.start_step ? active_q : '0;
      if (ctrl_i.start_begin) work_d[start_q] = 1'b1;
    end
    if (ctrl_i.scan_issue) scan_d[scan_idx] = 1'b0;
    if (ctrl_i.clo_issue)  work_d[work_idx] = 1'b0;
    if (ctrl_i.scan_proc) begin
      if (!rd_q.label[LABEL_W-1] && rd_q.label[SYM_W-1:0] == sym_q && ptr_valid(rd_q.nxt)) begin
        work_d[rd_q.nxt[STATE_W-1:0]] = 1'b1;
      end
    end
    if (ctrl_i.clo_proc) begin
      if (rd_q.label == LBL_EPS) begin
        // expand each split once so epsilon cycles end
        if (!seen_q[cur_q]) begin
          seen_d[cur_q] = 1'b1;
          if (ptr_valid(rd_q.nxt)) work_d[rd_q.nxt[STATE_W-1:0]] = 1'b1;
          if (ptr_valid(rd_q.alt)) work_d[rd_q.alt[STATE_W-1:0]] = 1'b1;
        end
      end else begin
        pend_d[cur_q] = 1'b1;
        if (rd_q.label == LBL_ACCEPT) acc_d = 1'b1;
      end
    end
    if (ctrl_i.commit) begin
      active_d  = pend_q;
    end
  end

  assign res_valid_d = ctrl_i.res_load ? 1'b1 : (out_ready_i ? 1'b0 : res_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q      <= '0;
      work_q      <= '0;
      seen_q      <= '0;
      pend_q      <= '0;
      acc_q       <= 1'b0;
      active_q    <= '0;
      last_q      <= 1'b0;
      start_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      scan_q      <= scan_d;
      work_q      <= work_d;
      seen_q      <= seen_d;
      pend_q      <= pend_d;
      acc_q       <= acc_d;
      active_q    <= active_d;
      last_q      <= last_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i) start_q <= cfg_start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.res_load) res_q <= acc_q;
  end

  assign stat_o.scan_empty = (scan_q == '0);
  assign stat_o.work_empty = (work_q == '0);
  assign stat_o.out_free   = !res_valid_q || out_ready_i;
  assign stat_o.last       = last_q;

  assign out_valid_o    = res_valid_q;
  assign out_accepted_o = res_q;

endmodule
`default_nettype wire

[sv/nfa_regex_state_set_matcher.sv]
// Top level of the Thompson NFA state-set matcher.
// Channels: in_i carries items (load entry, begin string, consume byte),
// out_o carries one accepted bit per item marked is_last (begin or consume),
// cfg_i writes start_state and is always ready; write it only while idle.
// Steps: a load writes its table entry while idle. A begin runs the
// closure of start_state; a consume scans the active states for the
// byte, then runs the closure; each visited state takes an issue step
// and a process step, and both end in the finish step. A split adds at
// most two states, so a closure visits at most 3*64 states. Rate is set
// by the single read port of the NFA table, read once per visited state
// with a registered read. Reset clears the active set, start_state and
// the result valid flag; the table is undefined until loaded. The result
// sits in an output register; the next item is accepted while it waits,
// and a later result holds in the finish step until the receiver takes
// the earlier one.
`default_nettype none
module nfa_regex_state_set_matcher (
  input  logic        clk_i,
  input  logic        rst_ni,
  nfa_in_if.sink      in_i,
  nfa_out_if.source   out_o,
  nfa_cfg_if.sink     cfg_i
);
  import nfa_pkg::*;

  ctrl_t ctrl;
  stat_t stat;
  logic  in_ready;

  assign in_i.ready  = in_ready;
  assign cfg_i.ready = 1'b1;

  nfa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_cmd_i   (in_i.cmd),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  nfa_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .stat_o         (stat),
    .entry_index_i  (in_i.entry_index),
    .entry_label_i  (in_i.entry_label),
    .entry_next_i   (in_i.entry_next),
    .entry_alt_i    (in_i.entry_alt),
    .symbol_i       (in_i.symbol),
    .is_last_i      (in_i.is_last),
    .cfg_we_i       (cfg_i.valid),
    .cfg_start_i    (cfg_i.start_state),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .out_accepted_o (out_o.accepted)
  );

endmodule
`default_nettype wire

[sv/nfa_chk.sv]
// Port-level checker of the matcher, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module nfa_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic [1:0] in_cmd_i,
  input logic       out_valid_i,
  input logic       out_ready_i
);
  import nfa_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  `ASSERT_NEXT(a_load_one_cycle, clk_i, rst_ni, in_acc && in_cmd_i == CMD_LOAD, in_ready_i)
  `ASSERT_NEXT(a_match_busy, clk_i, rst_ni,
               in_acc && (in_cmd_i == CMD_BEGIN || in_cmd_i == CMD_STEP), !in_ready_i)
  `ASSERT_SAME(a_result_from_busy, clk_i, rst_ni, $rose(out_valid_i), !$past(in_ready_i))
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)

endmodule

bind nfa_regex_state_set_matcher nfa_chk u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_cmd_i    (in_i.cmd),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready)
);
`default_nettype wire

[tb/sv/testbench.sv]
// Self-checking testbench of the Thompson NFA matcher: directed table, then random strings.
`default_nettype none
module testbench;
  import nfa_pkg::*;

  typedef struct {
    cmd_e       cmd;
    logic [5:0] idx;
    logic [8:0] label;
    logic [6:0] nxt;
    logic [6:0] alt;
    logic [7:0] sym;
    logic       last;
    bit         typed;   // expected result given in the item itself
    logic       want;
  } item_t;

  localparam int WATCHDOG_LIMIT = 6000;
  localparam int DRAIN_CYCLES   = 1000;
  localparam int LONG_HOLD      = 600;

  logic clk_i;
  logic rst_ni;

  nfa_in_if  in_if ();
  nfa_out_if out_if ();
  nfa_cfg_if cfg_if ();

  nfa_regex_state_set_matcher i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // Mirror of the block state
  logic [8:0]  lbl_mem [NUM_STATES];
  logic [6:0]  nxt_mem [NUM_STATES];
  logic [6:0]  alt_mem [NUM_STATES];
  logic [63:0] live_states;
  logic [5:0]  start_reg;

  logic verdict_q[$];
  int   n_errors;
  int   n_items;
  int   n_results;
  int   n_accepts;
  int   idle_cycles = 0;
  bit   gaps_on;
  bit   hold_req;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [63:0] closure_of(input logic [6:0] root);
    logic [63:0] res;
    logic [63:0] seen;
    logic [6:0]  stack [2*NUM_STATES+2];
    int          sp;
    logic [6:0]  s;
    res = '0;
    seen = '0;
    sp = 0;
    stack[sp++] = root;
    while (sp > 0) begin
      s = stack[--sp];
      if (s < NUM_STATES) begin
        if (lbl_mem[s[5:0]] == LBL_EPS) begin
          if (!seen[s[5:0]]) begin
            seen[s[5:0]] = 1'b1;
            stack[sp++] = alt_mem[s[5:0]];
            stack[sp++] = nxt_mem[s[5:0]];
          end
        end else begin
          res[s[5:0]] = 1'b1;
        end
      end
    end
    return res;
  endfunction

  // Advance the mirror by one item and queue the verdict it produces
  function automatic void predict_verdict(input item_t it);
    logic [63:0] nxt_set;
    logic        hit;
    case (it.cmd)
      CMD_LOAD: begin
        lbl_mem[it.idx] = it.label;
        nxt_mem[it.idx] = it.nxt;
        alt_mem[it.idx] = it.alt;
        return;
      end
      CMD_BEGIN: live_states = closure_of({1'b0, start_reg});
      CMD_STEP: begin
        nxt_set = '0;
        for (int i = 0; i < NUM_STATES; i++)
          if (live_states[i] && lbl_mem[i] < 9'd256 && lbl_mem[i][7:0] == it.sym)
            nxt_set |= closure_of(nxt_mem[i]);
        live_states = nxt_set;
      end
      default: return;
    endcase
    if (it.last) begin
      hit = 1'b0;
      for (int i = 0; i < NUM_STATES; i++)
        if (live_states[i] && lbl_mem[i] == LBL_ACCEPT) hit = 1'b1;
      if (it.typed && it.want !== hit) begin
        n_errors++;
        if (n_errors <= 10)
          $display("directed row disagrees with prediction: typed %0b predicted %0b",
                   it.want, hit);
      end
      verdict_q = {verdict_q, (it.typed ? it.want : hit)};
    end
  endfunction

  function automatic item_t mk(cmd_e c, int idx, int label, int nxt, int alt, int sym,
                               int last, bit typed = 0, bit want = 0);
    item_t it;
    it.cmd = c;  it.idx = 6'(idx);  it.label = 9'(label);  it.nxt = 7'(nxt);
    it.alt = 7'(alt);  it.sym = 8'(sym);  it.last = 1'(last);
    it.typed = typed;  it.want = want;
    return it;
  endfunction

  task automatic send_item(input item_t it);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.cmd         <= it.cmd;
    in_if.entry_index <= it.idx;
    in_if.entry_label <= it.label;
    in_if.entry_next  <= it.nxt;
    in_if.entry_alt   <= it.alt;
    in_if.symbol      <= it.sym;
    in_if.is_last     <= it.last;
    do @(negedge clk_i); while (!in_if.ready);
    @(posedge clk_i);
    predict_verdict(it);
    n_items++;
  endtask

  task automatic write_start(input logic [5:0] v);
    cfg_if.valid       <= 1'b1;
    cfg_if.start_state <= v;
    do @(negedge clk_i); while (!cfg_if.ready);
    @(posedge clk_i);
    start_reg = v;
    cfg_if.valid <= 1'b0;
  endtask

  // Hold until all verdicts are in and any trailing work has drained
  task automatic settle();
    in_if.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic item_t rand_entry(input int idx);
    int r;
    int lbl;
    r = $urandom_range(0, 99);
    if (r < 40)      lbl = 8'h61 + $urandom_range(0, 3);
    else if (r < 65) lbl = LBL_EPS;
    else if (r < 77) lbl = LBL_ACCEPT;
    else if (r < 92) lbl = $urandom_range(0, 255);
    else             lbl = $urandom_range(258, 511);
    return mk(CMD_LOAD, idx, lbl,
              ($urandom_range(0, 9) == 0) ? $urandom_range(64, 127) : $urandom_range(0, 63),
              ($urandom_range(0, 9) == 0) ? $urandom_range(64, 127) : $urandom_range(0, 63),
              $urandom_range(0, 255), $urandom_range(0, 1));
  endfunction

  function automatic int rand_sym();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7)       return 8'h61 + $urandom_range(0, 3);
    else if (r == 7) return 8'h00;
    else if (r == 8) return 8'hFF;
    return $urandom_range(0, 255);
  endfunction

  // One string: begin, up to eight bytes, last on the final item; sometimes noise
  task automatic send_string();
    int len;
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) begin
      send_item(rand_entry($urandom_range(0, 63)));
    end else if (r == 1) begin
      send_item(mk(CMD_NONE, $urandom_range(0, 63), $urandom_range(0, 511),
                   $urandom_range(0, 127), $urandom_range(0, 127),
                   $urandom_range(0, 255), $urandom_range(0, 1)));
    end else if (r == 2) begin
      // broken string: a byte with no begin
      send_item(mk(CMD_STEP, 0, 0, 0, 0, rand_sym(), $urandom_range(0, 1)));
    end else begin
      len = $urandom_range(0, 8);
      send_item(mk(CMD_BEGIN, $urandom_range(0, 63), 0, 0, 0, 0, len == 0));
      for (int k = 1; k <= len; k++)
        send_item(mk(CMD_STEP, 0, 0, 0, 0, rand_sym(), k == len));
    end
  endtask

  // Receiver: random stall bursts, plus one long hold on request
  initial begin
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Verdict checker; values are stable at the falling edge before the accepting edge
  always @(negedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      n_results++;
      n_accepts += out_if.accepted;
      if (verdict_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected result beat: accepted=%0b", out_if.accepted);
      end else if (out_if.accepted !== verdict_q.pop_front()) begin
        n_errors++;
        if (n_errors <= 10)
          $display("result mismatch #%0d: expected %0b got %0b",
                   n_results, ~out_if.accepted, out_if.accepted);
      end
    end
  end

  // Watchdog on cycles without any beat
  always @(negedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
        || (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL nfa_regex_state_set_matcher");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    item_t dir_rows [$];
    int    starts [4];
    in_if.valid       = 1'b0;
    in_if.cmd         = CMD_NONE;
    in_if.entry_index = '0;
    in_if.entry_label = '0;
    in_if.entry_next  = '0;
    in_if.entry_alt   = '0;
    in_if.symbol      = '0;
    in_if.is_last     = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.start_state = '0;
    n_errors = 0;  n_items = 0;  n_results = 0;  n_accepts = 0;
    gaps_on = 1'b1;
    hold_req = 1'b0;
    start_reg = '0;
    live_states = '0;
    for (int i = 0; i < NUM_STATES; i++) begin
      lbl_mem[i] = '0;  nxt_mem[i] = '0;  alt_mem[i] = '0;
    end

    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_start(6'd0);

    // Tiny NFA: 0 splits to 1 ('a' -> 2 accept) and 3 (0xFF -> back to 0)
    dir_rows = {dir_rows, mk(CMD_LOAD, 0, LBL_EPS, 1, 3, 0, 0)};
    dir_rows = {dir_rows, mk(CMD_LOAD, 1, 8'h61, 2, 64, 0, 0)};
    dir_rows = {dir_rows, mk(CMD_LOAD, 2, LBL_ACCEPT, 127, 127, 0, 0)};
    dir_rows = {dir_rows, mk(CMD_LOAD, 3, 8'hFF, 0, 0, 0, 0)};
    dir_rows = {dir_rows, mk(CMD_BEGIN, 0, 0, 0, 0, 0, 1, 1, 0)};     // empty string
    dir_rows = {dir_rows, mk(CMD_BEGIN, 0, 0, 0, 0, 0, 0)};
    dir_rows = {dir_rows, mk(CMD_STEP, 0, 0, 0, 0, 8'h61, 1, 1, 1)};
    dir_rows = {dir_rows, mk(CMD_BEGIN, 0, 0, 0, 0, 0, 0)};
    dir_rows = {dir_rows, mk(CMD_STEP, 0, 0, 0, 0, 8'hFF, 0)};
    dir_rows = {dir_rows, mk(CMD_STEP, 0, 0, 0, 0, 8'h61, 1, 1, 1)};
    dir_rows = {dir_rows, mk(CMD_STEP, 0, 0, 0, 0, 8'h00, 1, 1, 0)};  // dead set
    dir_rows = {dir_rows, mk(CMD_NONE, 63, 511, 127, 127, 255, 1)};   // unused command
    dir_rows = {dir_rows, mk(CMD_LOAD, 4, 511, 127, 127, 255, 1)};    // load marked last
    // epsilon cycle 5 <-> 6 around a byte state 7
    dir_rows = {dir_rows, mk(CMD_LOAD, 5, LBL_EPS, 6, 7, 0, 0)};
    dir_rows = {dir_rows, mk(CMD_LOAD, 6, LBL_EPS, 5, 64, 0, 0)};
    dir_rows = {dir_rows, mk(CMD_LOAD, 7, 8'h00, 6, 4, 0, 0)};
    dir_rows = {dir_rows, mk(CMD_LOAD, 0, LBL_EPS, 5, 2, 0, 0)};
    dir_rows = {dir_rows, mk(CMD_BEGIN, 0, 0, 0, 0, 0, 1, 1, 1)};
    dir_rows = {dir_rows, mk(CMD_STEP, 0, 0, 0, 0, 8'h00, 0)};
    dir_rows = {dir_rows, mk(CMD_STEP, 0, 0, 0, 0, 8'h00, 1, 1, 0)};
    dir_rows = {dir_rows, mk(CMD_BEGIN, 0, 0, 0, 0, 0, 0)};
    dir_rows = {dir_rows, mk(CMD_STEP, 0, 0, 0, 0, 8'h61, 1)};
    foreach (dir_rows[i]) send_item(dir_rows[i]);
    settle();

    // Fill the whole table so any pointer is safe from here on
    for (int i = 0; i < NUM_STATES; i++) send_item(rand_entry(i));

    starts[0] = 63;
    starts[1] = 0;
    starts[2] = $urandom_range(1, 62);
    starts[3] = $urandom_range(0, 63);
    for (int p = 0; p < 4; p++) begin
      settle();
      write_start(6'(starts[p]));
      if (p == 3) gaps_on = 1'b0;
      for (int n = 0; n < 80; n++) begin
        if (p == 1 && n == 20) hold_req = 1'b1;
        // a fresh table now and then keeps the automaton varied
        if (n % 40 == 39)
          for (int i = 0; i < NUM_STATES; i++) send_item(rand_entry(i));
        send_string();
      end
    end

    settle();
    n_errors += verdict_q.size();
    $display("Run covered %0d items and %0d end-of-string results (%0d accepted),",
             n_items, n_results, n_accepts);
    $display("across four start states with the extremes, table reloads and a long stall.");
    if (n_errors == 0) begin
      $display("PASS nfa_regex_state_set_matcher");
    end else begin
      $display("FAIL nfa_regex_state_set_matcher");
    end
    $finish;
  end

endmodule
`default_nettype wire
